/* design/bmff_pkg.sv */
// Shared types and constants for the ISO-BMFF top-level box chain checker.
// Depends on nothing; every other design file refers to it by scoped names.
package bmff_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned TotalW = 63;
  localparam int unsigned WordW  = 32;
  localparam int unsigned LargeW = 64;
  localparam int unsigned CountW = 4;

  localparam logic [WordW-1:0] TypeMoov = 32'h6D6F_6F76;
  localparam logic [WordW-1:0] TypeMoof = 32'h6D6F_6F66;
  localparam logic [WordW-1:0] TypeMdat = 32'h6D64_6174;

  localparam logic [CountW:0]  HdrShort = 5'd8;
  localparam logic [CountW:0]  HdrLong  = 5'd16;
  localparam logic [TotalW-1:0] TotalMax = {TotalW{1'b1}};

  typedef enum logic [2:0] {
    ErrNone        = 3'd0,
    ErrTooSmall    = 3'd1,
    ErrLargeUnread = 3'd2,
    ErrBadLarge    = 3'd3,
    ErrSizeSmall   = 3'd4,
    ErrTruncated   = 3'd5,
    ErrResidue     = 3'd6,
    ErrNoPayload   = 3'd7
  } bmff_err_e;

  typedef struct packed {
    logic              valid_res;
    bmff_err_e         error_code;
    logic [TotalW-1:0] byte_total;
  } bmff_result_t;

  function automatic logic is_payload_type(input logic [WordW-1:0] box_type);
    return (box_type == TypeMoov) || (box_type == TypeMoof) || (box_type == TypeMdat);
  endfunction

endpackage

/* design/bmff_walker.sv */
// Box chain walker: per-byte header gathering, payload countdown and final verdict.
// Depends on bmff_pkg for constants, the error enum and the result struct.
module bmff_walker (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    item_valid_i,
  input  logic [7:0]              item_byte_i,
  input  logic                    item_last_i,
  output logic                    push_o,
  output bmff_pkg::bmff_result_t  push_data_o
);

  logic [31:0] size_q, size_d;
  logic [31:0] type_q, type_d;
  logic [63:0] large_q, large_d;
  logic [3:0]  hc_q, hc_d;
  logic [62:0] payload_q, payload_d;
  logic        rte_q, rte_d;
  logic        seen_q, seen_d;
  bmff_pkg::bmff_err_e err_q, err_d;
  logic [62:0] bytes_q, bytes_d;
  logic [4:0]  hc_inc;
  bmff_pkg::bmff_err_e verdict;

  always_comb begin
    size_d    = size_q;
    type_d    = type_q;
    large_d   = large_q;
    hc_d      = hc_q;
    payload_d = payload_q;
    rte_d     = rte_q;
    seen_d    = seen_q;
    err_d     = err_q;
    bytes_d   = (bytes_q == bmff_pkg::TotalMax) ? bytes_q : bytes_q + 63'd1;
    hc_inc    = {1'b0, hc_q} + 5'd1;
    if (err_q == bmff_pkg::ErrNone && !rte_q) begin
      if (payload_q != '0) begin
        payload_d = payload_q - 63'd1;
      end else begin
        if (hc_q < 4'd4) begin
          size_d = {size_q[23:0], item_byte_i};
        end else if (hc_q < 4'd8) begin
          type_d = {type_q[23:0], item_byte_i};
        end else begin
          large_d = {large_q[55:0], item_byte_i};
        end
        hc_d = hc_inc[3:0];
        if (hc_inc == bmff_pkg::HdrShort) begin
          if (size_d == 32'd1) begin
            // A largesize follows; keep gathering.
          end else if (size_d == 32'd0) begin
            rte_d  = 1'b1;
            seen_d = seen_q | bmff_pkg::is_payload_type(type_d);
            hc_d   = '0;
          end else if (size_d < 32'd8) begin
            err_d = bmff_pkg::ErrSizeSmall;
            hc_d  = '0;
          end else begin
            payload_d = {31'd0, size_d - 32'd8};
            seen_d    = seen_q | bmff_pkg::is_payload_type(type_d);
            hc_d      = '0;
          end
        end else if (hc_inc == bmff_pkg::HdrLong) begin
          if (large_d[63] || large_d < 64'd16) begin
            err_d = bmff_pkg::ErrBadLarge;
          end else begin
            payload_d = large_d[62:0] - 63'd16;
            seen_d    = seen_q | bmff_pkg::is_payload_type(type_q);
          end
          hc_d = '0;
        end
      end
    end
  end

  // Verdict for a final byte, in priority order.
  always_comb begin
    priority if (bytes_d < 63'd8) begin
      verdict = bmff_pkg::ErrTooSmall;
    end else if (err_d != bmff_pkg::ErrNone) begin
      verdict = err_d;
    end else if (hc_d != '0 && hc_d < 4'd8) begin
      verdict = bmff_pkg::ErrResidue;
    end else if (hc_d >= 4'd8) begin
      verdict = bmff_pkg::ErrLargeUnread;
    end else if (!rte_d && payload_d != '0) begin
      verdict = bmff_pkg::ErrTruncated;
    end else if (!seen_d) begin
      verdict = bmff_pkg::ErrNoPayload;
    end else begin
      verdict = bmff_pkg::ErrNone;
    end
  end

  assign push_o                 = item_valid_i & item_last_i;
  assign push_data_o.valid_res  = (verdict == bmff_pkg::ErrNone);
  assign push_data_o.error_code = verdict;
  assign push_data_o.byte_total = bytes_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q    <= '0;
      type_q    <= '0;
      large_q   <= '0;
      hc_q      <= '0;
      payload_q <= '0;
      rte_q     <= 1'b0;
      seen_q    <= 1'b0;
      err_q     <= bmff_pkg::ErrNone;
      bytes_q   <= '0;
    end else if (item_valid_i && item_last_i) begin
      size_q    <= '0;
      type_q    <= '0;
      large_q   <= '0;
      hc_q      <= '0;
      payload_q <= '0;
      rte_q     <= 1'b0;
      seen_q    <= 1'b0;
      err_q     <= bmff_pkg::ErrNone;
      bytes_q   <= '0;
    end else if (item_valid_i) begin
      size_q    <= size_d;
      type_q    <= type_d;
      large_q   <= large_d;
      hc_q      <= hc_d;
      payload_q <= payload_d;
      rte_q     <= rte_d;
      seen_q    <= seen_d;
      err_q     <= err_d;
      bytes_q   <= bytes_d;
    end
  end

endmodule

/* design/bmff_fifo.sv */
// Three-entry result queue between the walker and the output channel.
// Depends on bmff_pkg for the result struct.
module bmff_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  bmff_pkg::bmff_result_t  push_data_i,
  input  logic                    pop_i,
  output logic                    not_empty_o,
  output logic [1:0]              count_o,
  output bmff_pkg::bmff_result_t  head_o
);

  bmff_pkg::bmff_result_t slot_q [3];
  logic [1:0] wr_q, rd_q, count_q;

  function automatic logic [1:0] next_ptr(input logic [1:0] ptr);
    return (ptr == 2'd2) ? 2'd0 : ptr + 2'd1;
  endfunction

  assign not_empty_o = (count_q != 2'd0);
  assign count_o     = count_q;
  assign head_o      = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= next_ptr(wr_q);
      end
      if (pop_i) begin
        rd_q <= next_ptr(rd_q);
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

/* design/iso_bmff_box_chain_checker.sv */
// Top level of the ISO-BMFF top-level box chain checker.
// Depends on bmff_pkg, bmff_walker and bmff_fifo.
//
// Usage: the input channel carries one word per cycle, a file byte (data_byte_i)
// and a mark on the final byte of the file (last_byte_i). A word is taken at a rising
// edge where in_valid_i is high and in_stall_o is low. The output channel carries one
// verdict word per file (valid_res_o, error_code_o, byte_total_o), taken at an edge
// where out_valid_o is high and out_stall_i is low.
// Throughput is one byte per cycle while in_stall_o is low. Each byte first lands in
// an input register, and in the next cycle the walker updates the box state from it;
// a final byte also pushes its verdict into a three-entry result queue. When the
// queue is empty, out_valid_o rises as soon as the queue holds that verdict, so a
// final byte reaches the output through the input register and the queue.
// When the receiver stalls, verdicts wait in the queue and bytes keep flowing. The
// input stalls only when the queue could otherwise overflow: three results waiting,
// or two waiting with one byte in the input register.
// An asynchronous low reset empties the input register and the queue and clears all
// box state, so the block starts at the first byte of a new file. After each verdict
// the box state returns to that same starting point on its own.
module iso_bmff_box_chain_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        valid_res_o,
  output logic [2:0]  error_code_o,
  output logic [62:0] byte_total_o
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       accept;

  logic                   push;
  bmff_pkg::bmff_result_t push_data;
  bmff_pkg::bmff_result_t head;
  logic [1:0]             count;
  logic                   not_empty;

  // The stall looks only at registered state, so it never waits on out_stall_i.
  assign in_stall_o = (count == 2'd3) || (count == 2'd2 && in_valid_q);
  assign accept     = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept;
    end
  end

  // The payload needs no reset; it is qualified by in_valid_q.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= data_byte_i;
      in_last_q <= last_byte_i;
    end
  end

  // The walker consumes the registered byte every cycle; the stall rule above
  // guarantees the queue has room for any verdict it pushes.
  bmff_walker u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (in_valid_q),
    .item_byte_i  (in_byte_q),
    .item_last_i  (in_last_q),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  bmff_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (not_empty & ~out_stall_i),
    .not_empty_o (not_empty),
    .count_o     (count),
    .head_o      (head)
  );

  assign out_valid_o  = not_empty;
  assign valid_res_o  = head.valid_res;
  assign error_code_o = head.error_code;
  assign byte_total_o = head.byte_total;

endmodule

/* design/bmff_checker.sv */
// Port-level checks for the ISO-BMFF box chain checker, bound to its top level.
// Depends on bmff_pkg for the error codes.
module bmff_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        last_byte_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        valid_res_o,
  input logic [2:0]  error_code_o,
  input logic [62:0] byte_total_o
);

  // A stalled verdict word stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("verdict word dropped while stalled");

  // The pass flag agrees with the error code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (valid_res_o == (error_code_o == bmff_pkg::ErrNone)))
    else $error("valid_res disagrees with error_code");

  // A too-small verdict goes with fewer than eight bytes, and only then.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((error_code_o == bmff_pkg::ErrTooSmall) == (byte_total_o < 63'd8)))
    else $error("too-small verdict inconsistent with byte count");

  // A verdict appears on an empty output only for an accepted final byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o && last_byte_i, 2))
    else $error("verdict without a final byte");

endmodule

bind iso_bmff_box_chain_checker bmff_checker u_bmff_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .last_byte_i  (last_byte_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .valid_res_o  (valid_res_o),
  .error_code_o (error_code_o),
  .byte_total_o (byte_total_o)
);

/* test/tb_iso_bmff_box_chain_checker.sv */
// Self-checking testbench for iso_bmff_box_chain_checker: a table of hand-built files
// followed by random files, checked word by word against typed verdicts or the predictor.
// Depends on bmff_pkg and the design top level only.
module tb_iso_bmff_box_chain_checker;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] TypeFree = 32'h6672_6565;
  localparam logic [31:0] TypeSkip = 32'h736B_6970;

  // Least number of random file bytes to send after the table, and the length of the
  // closing stretch in which neither side idles.
  localparam int unsigned RandomBytes = 600;
  localparam int unsigned CalmWords   = 60;
  // The long receiver hold-off, in cycles. With files of a few dozen bytes this
  // is long enough for the three-entry result queue to fill and stall the input.
  localparam int unsigned HoldCycles  = 400;

  // One hand-built file: the head bytes are right-justified (the last head byte
  // sits in the low bits), followed by fill_len copies of fill_val. Where typed is
  // set, code is the verdict read straight off the format rules; otherwise the
  // predictor decides.
  typedef struct packed {
    logic [191:0]        head;
    logic [4:0]          head_len;
    logic [4:0]          fill_len;
    logic [7:0]          fill_val;
    logic                typed;
    bmff_pkg::bmff_err_e code;
  } probe_row_t;

  // One word for the input channel, plus the typed verdict when the word ends a
  // table file that carries one.
  typedef struct packed {
    logic [7:0]             data;
    logic                   last;
    logic                   typed;
    bmff_pkg::bmff_result_t verdict;
  } stim_word_t;

  localparam probe_row_t ProbeFiles [18] = '{
    // A one-byte file and a seven-byte file are both too small.
    '{192'({8'hFF}), 5'd1, 5'd0, 8'h00, 1'b1, bmff_pkg::ErrTooSmall},
    '{192'({32'd8, 24'h6D6461}), 5'd7, 5'd0, 8'h00, 1'b1, bmff_pkg::ErrTooSmall},
    // A size below eight sticks; the fill bytes are only counted.
    '{192'({32'd4, TypeFree}), 5'd8, 5'd3, 8'hFF, 1'b1, bmff_pkg::ErrSizeSmall},
    // Largesize below sixteen, and largesize with its top bit set.
    '{192'({32'd1, bmff_pkg::TypeMdat, 64'd15}), 5'd16, 5'd0, 8'h00, 1'b1,
      bmff_pkg::ErrBadLarge},
    '{192'({32'd1, bmff_pkg::TypeMdat, 64'h8000_0000_0000_0020}), 5'd16, 5'd2, 8'h00,
      1'b1, bmff_pkg::ErrBadLarge},
    // Smallest legal largesize box, with no payload at all.
    '{192'({32'd1, bmff_pkg::TypeMdat, 64'd16}), 5'd16, 5'd0, 8'h00, 1'b1,
      bmff_pkg::ErrNone},
    // Payload owed when the file ends.
    '{192'({32'd12, bmff_pkg::TypeMoov}), 5'd8, 5'd2, 8'h00, 1'b1,
      bmff_pkg::ErrTruncated},
    // A partial second header is trailing residue.
    '{192'({32'd8, bmff_pkg::TypeMoov, 24'h000000}), 5'd11, 5'd0, 8'h00, 1'b1,
      bmff_pkg::ErrResidue},
    // The file stops inside a largesize field.
    '{192'({32'd1, bmff_pkg::TypeMoof, 32'h0000_0000}), 5'd12, 5'd0, 8'h00, 1'b1,
      bmff_pkg::ErrLargeUnread},
    // A clean chain without moov, moof or mdat.
    '{192'({32'd8, TypeFree}), 5'd8, 5'd0, 8'h00, 1'b1, bmff_pkg::ErrNoPayload},
    // Size zero runs to the end of the file, whatever follows.
    '{192'({32'd0, bmff_pkg::TypeMdat}), 5'd8, 5'd9, 8'hFF, 1'b1, bmff_pkg::ErrNone},
    '{192'({32'd0, TypeSkip}), 5'd8, 5'd0, 8'h00, 1'b1, bmff_pkg::ErrNoPayload},
    // All-ones header: a huge box that is never paid.
    '{192'({64'hFFFF_FFFF_FFFF_FFFF}), 5'd8, 5'd0, 8'h00, 1'b1, bmff_pkg::ErrTruncated},
    // Two boxes in a row, the second with a full payload.
    '{192'({32'd8, bmff_pkg::TypeMoof, 32'd16, bmff_pkg::TypeMoov}), 5'd16, 5'd8, 8'h00,
      1'b1, bmff_pkg::ErrNone},
    // Largest legal largesize, never paid.
    '{192'({32'd1, bmff_pkg::TypeMdat, 64'h7FFF_FFFF_FFFF_FFFF}), 5'd16, 5'd1, 8'hFF,
      1'b1, bmff_pkg::ErrTruncated},
    // Mixed chains left to the predictor.
    '{192'({32'd10, TypeFree, 16'hABCD, 32'd0, bmff_pkg::TypeMoof}), 5'd18, 5'd4, 8'h5A,
      1'b0, bmff_pkg::ErrNone},
    '{192'({32'd1, bmff_pkg::TypeMoov, 64'd17, 24'h5A0000}), 5'd19, 5'd0, 8'h00, 1'b0,
      bmff_pkg::ErrNone},
    '{192'({32'd9, bmff_pkg::TypeMdat, 8'h01, 32'd7}), 5'd13, 5'd4, 8'hA5, 1'b0,
      bmff_pkg::ErrNone}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        last_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        valid_res_o;
  logic [2:0]  error_code_o;
  logic [62:0] byte_total_o;

  iso_bmff_box_chain_checker u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .valid_res_o (valid_res_o),
    .error_code_o(error_code_o),
    .byte_total_o(byte_total_o)
  );

  always #6 clk_i = ~clk_i;

  // Predictor state: the box walker as the format defines it.
  logic [31:0]         chain_size;
  logic [31:0]         chain_type;
  logic [63:0]         chain_large;
  logic [4:0]          chain_hdr;
  logic [63:0]         chain_owed;
  logic                chain_to_end;
  logic                chain_found;
  bmff_pkg::bmff_err_e chain_err;
  logic [62:0]         chain_seen;

  stim_word_t             words_to_send[$];
  logic [7:0]             file_bytes[$];
  bmff_pkg::bmff_result_t verdicts_due[$];

  int unsigned faults = 0;
  int unsigned verdicts_checked = 0;
  int unsigned files_sent = 0;
  int unsigned input_held = 0;
  logic        hold_go = 1'b0;
  logic        calm_tail = 1'b0;

  function automatic logic carries_media(input logic [31:0] box_type);
    return box_type == bmff_pkg::TypeMoov || box_type == bmff_pkg::TypeMoof ||
           box_type == bmff_pkg::TypeMdat;
  endfunction

  function automatic void chain_clear();
    chain_size   = '0;
    chain_type   = '0;
    chain_large  = '0;
    chain_hdr    = '0;
    chain_owed   = '0;
    chain_to_end = 1'b0;
    chain_found  = 1'b0;
    chain_err    = bmff_pkg::ErrNone;
    chain_seen   = '0;
  endfunction

  // Advances the walker by one accepted byte. On the final byte of a file it
  // returns the verdict and starts over for the next file.
  task automatic chain_take(input logic [7:0] b, input logic last, output logic done,
                            output bmff_pkg::bmff_result_t verdict);
    bmff_pkg::bmff_err_e code;
    if (chain_seen != bmff_pkg::TotalMax) chain_seen++;

    // Once an error has stuck, bytes are only counted.
    if (chain_err == bmff_pkg::ErrNone && !chain_to_end) begin
      if (chain_owed != 0) begin
        chain_owed--;
      end else begin
        if (chain_hdr < 5'd4) chain_size = {chain_size[23:0], b};
        else if (chain_hdr < bmff_pkg::HdrShort) chain_type = {chain_type[23:0], b};
        else chain_large = {chain_large[55:0], b};
        chain_hdr++;

        if (chain_hdr == bmff_pkg::HdrShort && chain_size != 32'd1) begin
          // Short header done. Size one keeps gathering the largesize instead.
          if (chain_size == 32'd0) begin
            chain_to_end = 1'b1;
            chain_found  = chain_found | carries_media(chain_type);
          end else if (chain_size < 32'd8) begin
            chain_err = bmff_pkg::ErrSizeSmall;
          end else begin
            chain_owed  = {32'd0, chain_size} - 64'd8;
            chain_found = chain_found | carries_media(chain_type);
          end
          chain_hdr = '0;
        end else if (chain_hdr == bmff_pkg::HdrLong) begin
          if (chain_large[63] || chain_large < 64'd16) begin
            chain_err = bmff_pkg::ErrBadLarge;
          end else begin
            chain_owed  = chain_large - 64'd16;
            chain_found = chain_found | carries_media(chain_type);
          end
          chain_hdr = '0;
        end
      end
    end

    done    = last;
    verdict = '0;
    if (last) begin
      // Verdict priority follows the order in which the format is judged.
      if (chain_seen < 63'd8) code = bmff_pkg::ErrTooSmall;
      else if (chain_err != bmff_pkg::ErrNone) code = chain_err;
      else if (chain_hdr > 5'd0 && chain_hdr < bmff_pkg::HdrShort) code = bmff_pkg::ErrResidue;
      else if (chain_hdr >= bmff_pkg::HdrShort) code = bmff_pkg::ErrLargeUnread;
      else if (!chain_to_end && chain_owed != 0) code = bmff_pkg::ErrTruncated;
      else if (!chain_found) code = bmff_pkg::ErrNoPayload;
      else code = bmff_pkg::ErrNone;
      verdict.valid_res  = (code == bmff_pkg::ErrNone);
      verdict.error_code = code;
      verdict.byte_total = chain_seen;
      chain_clear();
    end
  endtask

  // Appends the low n bytes of v to the file under construction, big-endian.
  task automatic append_be(input logic [63:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) file_bytes = {file_bytes, v[8*i +: 8]};
  endtask

  function automatic logic [31:0] pick_box_type();
    case ($urandom_range(0, 4))
      0: return bmff_pkg::TypeMoov;
      1: return bmff_pkg::TypeMoof;
      2: return bmff_pkg::TypeMdat;
      3: return TypeFree;
      default: return $urandom;
    endcase
  endfunction

  // Builds one random file and queues its words. Most files are well-formed box
  // chains with random payload, some of them broken on purpose; the rest are short
  // files and plain noise.
  task automatic add_random_file();
    int unsigned shape, flaw, nbox, style, plen, cut;
    logic [63:0] lsize;
    stim_word_t  w;
    file_bytes.delete();
    shape = $urandom_range(0, 99);
    if (shape < 70) begin
      flaw = $urandom_range(0, 11);
      if (flaw == 2) begin
        // Leading box whose size is below the header length (zero and one included).
        append_be(64'($urandom_range(0, 7)), 4);
        append_be(64'(pick_box_type()), 4);
      end else if (flaw == 3) begin
        // Leading box with a malformed largesize.
        append_be(64'd1, 4);
        append_be(64'(pick_box_type()), 4);
        if ($urandom_range(0, 1) == 1) lsize = {1'b1, 31'($urandom), 32'($urandom)};
        else lsize = 64'($urandom_range(0, 15));
        append_be(lsize, 8);
      end
      nbox = $urandom_range(1, 3);
      for (int unsigned bx = 0; bx < nbox; bx++) begin
        style = $urandom_range(0, 9);
        plen  = $urandom_range(0, 16);
        if (style >= 8 && bx == nbox - 1) begin
          append_be(64'd0, 4);
          append_be(64'(pick_box_type()), 4);
        end else if (style >= 6) begin
          append_be(64'd1, 4);
          append_be(64'(pick_box_type()), 4);
          // An occasional huge but legal largesize leaves the box unpaid.
          if (flaw == 4) lsize = {1'b0, 31'($urandom), 32'($urandom)};
          else lsize = 64'(16 + plen);
          append_be(lsize, 8);
        end else begin
          append_be(64'(8 + plen), 4);
          append_be(64'(pick_box_type()), 4);
        end
        repeat (plen) file_bytes = {file_bytes, 8'($urandom)};
      end
      if (flaw == 0) begin
        cut = $urandom_range(1, 10);
        while (cut > 0 && file_bytes.size() > 1) begin
          void'(file_bytes.pop_back());
          cut--;
        end
      end else if (flaw == 1) begin
        repeat ($urandom_range(1, 20)) file_bytes = {file_bytes, 8'($urandom)};
      end
    end else if (shape < 85) begin
      repeat ($urandom_range(1, 12)) file_bytes = {file_bytes, 8'($urandom)};
    end else begin
      repeat ($urandom_range(1, 40)) file_bytes = {file_bytes, 8'($urandom)};
    end

    w = '0;
    foreach (file_bytes[i]) begin
      w.data = file_bytes[i];
      w.last = (i == file_bytes.size() - 1);
      words_to_send = {words_to_send, w};
    end
  endtask

  // Output monitor. A verdict word is taken at a rising edge with out_valid_o high
  // and out_stall_i low; it must match the oldest verdict still due, field by field.
  // The same edge also counts cycles in which the block held back an offered word.
  always @(posedge clk_i) begin
    bmff_pkg::bmff_result_t due;
    if (rst_ni) begin
      if (in_valid_i && in_stall_o) input_held++;
      if (out_valid_o && !out_stall_i) begin
        if (verdicts_due.size() == 0) begin
          $error("verdict word with none due: valid_res %0d error_code %0d byte_total %0d",
                 valid_res_o, error_code_o, byte_total_o);
          faults++;
        end else begin
          due = verdicts_due.pop_front();
          verdicts_checked++;
          if (valid_res_o !== due.valid_res) begin
            $error("valid_res: expected %0d, actual %0d", due.valid_res, valid_res_o);
            faults++;
          end
          if (error_code_o !== due.error_code) begin
            $error("error_code: expected %0d, actual %0d", due.error_code, error_code_o);
            faults++;
          end
          if (byte_total_o !== due.byte_total) begin
            $error("byte_total: expected %0d, actual %0d", due.byte_total, byte_total_o);
            faults++;
          end
        end
      end
    end
  end

  // Receiver. It stalls in random bursts, sometimes leaves long stretches free,
  // and once, as soon as the random files start, holds off for a long count of
  // cycles while the sender keeps going, so that the result queue fills and the
  // block has to stall its input. In the closing stretch it starts no new stalls.
  initial begin
    int unsigned hold_left;
    logic        hold_done;
    hold_done   = 1'b0;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    while (!calm_tail) begin
      @(negedge clk_i);
      if (hold_go && !hold_done) begin
        hold_done   = 1'b1;
        out_stall_i <= 1'b1;
        for (hold_left = HoldCycles; hold_left > 0; hold_left--) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if ($urandom_range(0, 99) == 0) begin
        repeat (60) @(negedge clk_i);
      end else if ($urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Sender and run control. All words are built up front: the table files first,
  // then random files. Each word is driven at a falling edge and held until a
  // rising edge takes it; only then does the predictor see it.
  initial begin
    probe_row_t             row;
    stim_word_t             w;
    bmff_pkg::bmff_result_t predicted;
    logic                   done;
    int unsigned            n, gap_pct, random_from, tail_from;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    data_byte_i = '0;
    last_byte_i = 1'b0;
    chain_clear();

    foreach (ProbeFiles[r]) begin
      row = ProbeFiles[r];
      n   = row.head_len + row.fill_len;
      for (int unsigned k = 0; k < n; k++) begin
        w = '0;
        if (k < row.head_len) w.data = row.head[8*(row.head_len - 1 - k) +: 8];
        else w.data = row.fill_val;
        w.last  = (k == n - 1);
        w.typed = row.typed;
        w.verdict.valid_res  = (row.code == bmff_pkg::ErrNone);
        w.verdict.error_code = row.code;
        w.verdict.byte_total = 63'(n);
        words_to_send = {words_to_send, w};
      end
    end
    random_from = words_to_send.size();
    while (words_to_send.size() - random_from < RandomBytes) add_random_file();
    tail_from = words_to_send.size() - CalmWords;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    gap_pct = 0;
    for (int unsigned k = 0; k < words_to_send.size(); k++) begin
      w = words_to_send[k];
      if (k == random_from) hold_go = 1'b1;
      if (k == tail_from) begin
        calm_tail = 1'b1;
        gap_pct   = 0;
      end
      if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
      end
      in_valid_i  <= 1'b1;
      data_byte_i <= w.data;
      last_byte_i <= w.last;
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);

      chain_take(w.data, w.last, done, predicted);
      if (done) begin
        // Table files with a typed verdict are held to it; the rest to the predictor.
        verdicts_due = {verdicts_due, (w.typed ? w.verdict : predicted)};
        files_sent++;
        // Each file gets its own idling rate, zero included.
        if (!calm_tail) begin
          case ($urandom_range(0, 3))
            0: gap_pct = 0;
            1: gap_pct = 5;
            2: gap_pct = 15;
            default: gap_pct = 30;
          endcase
        end
      end
      @(negedge clk_i);
    end
    in_valid_i <= 1'b0;

    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Covered %0d files in %0d bytes (%0d from the directed table); %0d verdicts.",
             files_sent, words_to_send.size(), random_from, verdicts_checked);
    $display("Input back-pressure was seen on %0d cycles during receiver stalls.", input_held);
    if (faults == 0) begin
      $display("** iso_bmff_box_chain_checker: PASSED **");
    end else begin
      $display("** iso_bmff_box_chain_checker: FAILED **");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5ms;
    $display("** iso_bmff_box_chain_checker: FAILED **");
    $finish;
  end

endmodule
